[rtl/rsa_pkg.sv]
package rsa_pkg;

    localparam int MODE_W   = 3;
    localparam int PID_W    = 15;
    localparam int SLOT_W   = 8;
    localparam int OWNER_W  = 15;
    localparam int STATUS_W = 3;
    localparam int REFO_W   = 24;
    localparam int ALIVE_W  = 16;
    localparam int FREE_W   = 8;

    // pid field reaches at most this many map entries
    localparam int PID_SPAN = 32768;

    localparam logic [SLOT_W-1:0]  NONE_SLOT = 8'hFF;
    localparam logic [ALIVE_W-1:0] ALIVE_MAX = 16'hFFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 3'd0,
        MODE_ATTACH = 3'd1,
        MODE_DETACH = 3'd2,
        MODE_ADD    = 3'd3,
        MODE_DROP   = 3'd4,
        MODE_LOOKUP = 3'd5,
        MODE_READ   = 3'd6,
        MODE_NOP    = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_FREE    = 3'd1,
        ST_BAD_SLOT   = 3'd2,
        ST_ATTACHED   = 3'd3,
        ST_ALIVE_ZERO = 3'd4,
        ST_REF_ZERO   = 3'd5,
        ST_OVERFLOW   = 3'd6,
        ST_STACK_FULL = 3'd7
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_EXEC   = 5'b00100,
        S_SECOND = 5'b01000,
        S_PUSH   = 5'b10000
    } fsm_t;

    // first member is the most significant: mode sits in the lowest bits
    typedef struct packed {
        logic [OWNER_W-1:0] owner_id;
        logic [SLOT_W-1:0]  slot;
        logic [PID_W-1:0]   pid;
        mode_t              mode;
    } item_t;

    typedef struct packed {
        logic [FREE_W-1:0]  free_count;
        logic [OWNER_W-1:0] owner_out;
        logic [ALIVE_W-1:0] alive_count;
        logic [REFO_W-1:0]  ref_count;
        logic               released;
        logic [SLOT_W-1:0]  slot_out;
        status_t            status;
    } result_t;

    localparam int ITEM_W = $bits(item_t);
    localparam int RES_W  = $bits(result_t);
    localparam int IN_W   = ((ITEM_W + 7) / 8) * 8;
    localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

endpackage

[rtl/refcounted_slot_allocator.sv]
// Slot allocator with reference counts, run by single-item commands.
// Input channel s_*: one command item (mode, pid, slot, owner_id) per handshake.
// Result channel m_*: exactly one result item per command, in command order.
// A command is taken only while the block is idle. From accept to result, most
// commands read the process map and the slot table, then check, update and write
// back. Detach and lookup read the slot table at the slot found in the map, so
// they pass through a further state. A command that returns a slot to the free
// stack then writes the stack entry in a push state, since the stack shares the
// slot table's memory port.
// After reset the process map is swept to "not sandboxed", one entry a cycle:
// min(PROCESS_COUNT, 32768) entries, 32768 at the defaults; s_tready stays low
// until the sweep is done. Slot counts and the initial stack order come from
// valid bits cleared at reset.
// The result sits in an output register. A new command is accepted while a
// result still waits, but it is not finished until m_tready has taken the
// previous one.
module refcounted_slot_allocator
    import rsa_pkg::*;
#(
    parameter int PROCESS_COUNT = 32768,
    parameter int SLOT_COUNT    = 128,
    parameter int REF_BITS      = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // mode, pid, slot, owner_id
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, slot_out, released, ref_count,
                                        // alive_count, owner_out, free_count
);

    localparam int MAP_DEPTH = (PROCESS_COUNT < PID_SPAN) ? PROCESS_COUNT : PID_SPAN;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int TBL_AW    = $clog2(SLOT_COUNT);
    localparam int TBL_W     = REF_BITS + ALIVE_W + OWNER_W;
    localparam int MEM_W     = TBL_W + SLOT_W;

    localparam logic [REF_BITS-1:0] REF_MAX    = '1;
    localparam logic [REF_BITS-1:0] REF_ONE    = REF_BITS'(1);
    localparam logic [SLOT_W-1:0]   SLOT_LIMIT = SLOT_W'(SLOT_COUNT);
    localparam logic [31:0]         PID_LIMIT  = 32'(PROCESS_COUNT);
    localparam logic [MAP_AW-1:0]   MAP_LAST   = MAP_AW'(MAP_DEPTH - 1);

    fsm_t state_reg, state_next;
    item_t item_in, item_reg;
    result_t res_reg;
    logic m_valid_reg;
    logic [MAP_AW-1:0] clr_idx_reg;
    logic [FREE_W-1:0] free_top_reg;
    logic [FREE_W-1:0] stk_top;
    logic accept, out_free, commit;

    // process map memory
    logic [SLOT_W-1:0] map_mem [MAP_DEPTH];
    logic [SLOT_W-1:0] map_rd_reg;
    logic [MAP_AW-1:0] map_ra, map_wa;
    logic [SLOT_W-1:0] map_wd;
    logic map_we;

    // slot table memory: stack entry lane above count/owner lane
    logic [MEM_W-1:0]  slot_mem [SLOT_COUNT];
    logic [MEM_W-1:0]  slot_rd_reg;
    logic [TBL_AW-1:0] slot_ra, slot_ra_reg, slot_wa;
    logic [SLOT_COUNT-1:0] tbl_vld_reg, stk_vld_reg;
    logic tbl_we, stk_we;
    logic [TBL_W-1:0] tbl_wd;

    logic [REF_BITS-1:0] cur_refs, n_refs;
    logic [ALIVE_W-1:0]  cur_alive, n_alive;
    logic [OWNER_W-1:0]  cur_owner, n_owner;
    logic [SLOT_W-1:0]   stk_ent;
    logic pid_ok, slot_ok;

    logic fin, go_second, tbl_wr, map_wr, push, o_rel;
    status_t st;
    logic [SLOT_W-1:0] o_slot, map_wd_c;
    logic [FREE_W-1:0] ft_c;
    result_t res_c;

    assign item_in  = item_t'(s_tdata[ITEM_W-1:0]);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign commit   = fin && out_free;
    assign stk_top  = free_top_reg - FREE_W'(1);

    assign pid_ok  = 32'(item_reg.pid) < PID_LIMIT;
    assign slot_ok = item_reg.slot < SLOT_LIMIT;

    // ---------------- process map ----------------
    always_comb begin
        map_ra = (state_reg == S_IDLE) ? item_in.pid[MAP_AW-1:0] : item_reg.pid[MAP_AW-1:0];
        if (state_reg == S_CLEAR) begin
            map_we = 1'b1;
            map_wa = clr_idx_reg;
            map_wd = NONE_SLOT;
        end else begin
            map_we = commit && map_wr;
            map_wa = item_reg.pid[MAP_AW-1:0];
            map_wd = map_wd_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        map_rd_reg <= map_mem[map_ra];
    end

    // ---------------- slot table ----------------
    always_comb begin
        if (state_reg == S_IDLE) begin
            slot_ra = (item_in.mode == MODE_ALLOC) ? stk_top[TBL_AW-1:0]
                                                   : item_in.slot[TBL_AW-1:0];
        end else if (item_reg.mode == MODE_DETACH || item_reg.mode == MODE_LOOKUP) begin
            slot_ra = map_rd_reg[TBL_AW-1:0];
        end else if (item_reg.mode == MODE_ALLOC) begin
            slot_ra = stk_top[TBL_AW-1:0];
        end else begin
            slot_ra = item_reg.slot[TBL_AW-1:0];
        end
        // push goes to the old top, which is the new top minus one
        slot_wa = (state_reg == S_PUSH) ? stk_top[TBL_AW-1:0] : o_slot[TBL_AW-1:0];
        tbl_we  = commit && tbl_wr;
        stk_we  = (state_reg == S_PUSH);
        tbl_wd  = {n_refs, n_alive, n_owner};
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            slot_mem[slot_wa][TBL_W-1:0] <= tbl_wd;
        end
        if (stk_we) begin
            slot_mem[slot_wa][MEM_W-1:TBL_W] <= res_reg.slot_out;
        end
        slot_rd_reg <= slot_mem[slot_ra];
        slot_ra_reg <= slot_ra;
    end

    // entries never written read as their reset values
    always_comb begin
        if (tbl_vld_reg[slot_ra_reg]) begin
            cur_refs  = slot_rd_reg[TBL_W-1 -: REF_BITS];
            cur_alive = slot_rd_reg[OWNER_W +: ALIVE_W];
            cur_owner = slot_rd_reg[OWNER_W-1:0];
        end else begin
            cur_refs  = '0;
            cur_alive = '0;
            cur_owner = '0;
        end
        if (stk_vld_reg[slot_ra_reg]) begin
            stk_ent = slot_rd_reg[MEM_W-1:TBL_W];
        end else begin
            stk_ent = SLOT_LIMIT - SLOT_W'(1) - SLOT_W'(slot_ra_reg);
        end
    end

    // ---------------- command execution ----------------
    always_comb begin
        fin       = 1'b0;
        go_second = 1'b0;
        st        = ST_OK;
        o_slot    = NONE_SLOT;
        o_rel     = 1'b0;
        n_refs    = cur_refs;
        n_alive   = cur_alive;
        n_owner   = cur_owner;
        tbl_wr    = 1'b0;
        map_wr    = 1'b0;
        map_wd_c  = NONE_SLOT;
        ft_c      = free_top_reg;
        push      = 1'b0;

        if (state_reg == S_EXEC) begin
            case (item_reg.mode)
                MODE_ALLOC: begin
                    fin = 1'b1;
                    if (free_top_reg == '0) begin
                        st = ST_NO_FREE;
                    end else if (stk_ent >= SLOT_LIMIT) begin
                        st = ST_BAD_SLOT;
                    end else begin
                        o_slot  = stk_ent;
                        n_refs  = REF_ONE;
                        n_alive = '0;
                        n_owner = item_reg.owner_id;
                        tbl_wr  = 1'b1;
                        ft_c    = stk_top;
                    end
                end
                MODE_ATTACH: begin
                    fin = 1'b1;
                    if (!pid_ok) begin
                        st = ST_BAD_SLOT;
                    end else begin
                        o_slot = item_reg.slot;
                        if (!slot_ok) begin
                            st = ST_BAD_SLOT;
                        end else if (map_rd_reg != NONE_SLOT) begin
                            st = ST_ATTACHED;
                        end else if (cur_refs == REF_MAX || cur_alive == ALIVE_MAX) begin
                            st = ST_OVERFLOW;
                        end else begin
                            map_wr   = 1'b1;
                            map_wd_c = item_reg.slot;
                            n_refs   = cur_refs + REF_ONE;
                            n_alive  = cur_alive + ALIVE_W'(1);
                            tbl_wr   = 1'b1;
                        end
                    end
                end
                MODE_DETACH: begin
                    if (!pid_ok) begin
                        fin = 1'b1;
                        st  = ST_BAD_SLOT;
                    end else if (map_rd_reg == NONE_SLOT) begin
                        fin = 1'b1;
                    end else if (map_rd_reg >= SLOT_LIMIT) begin
                        fin    = 1'b1;
                        st     = ST_BAD_SLOT;
                        o_slot = map_rd_reg;
                    end else begin
                        go_second = 1'b1;
                    end
                end
                MODE_ADD: begin
                    fin    = 1'b1;
                    o_slot = item_reg.slot;
                    if (!slot_ok) begin
                        st = ST_BAD_SLOT;
                    end else if (cur_refs == REF_MAX) begin
                        st = ST_OVERFLOW;
                    end else begin
                        n_refs = cur_refs + REF_ONE;
                        tbl_wr = 1'b1;
                    end
                end
                MODE_DROP: begin
                    fin    = 1'b1;
                    o_slot = item_reg.slot;
                    if (!slot_ok) begin
                        st = ST_BAD_SLOT;
                    end else if (cur_refs == '0) begin
                        st = ST_REF_ZERO;
                    end else if (cur_refs == REF_ONE && free_top_reg >= SLOT_LIMIT) begin
                        st = ST_STACK_FULL;
                    end else begin
                        n_refs = cur_refs - REF_ONE;
                        tbl_wr = 1'b1;
                        if (cur_refs == REF_ONE) begin
                            o_rel = 1'b1;
                            push  = 1'b1;
                            ft_c  = free_top_reg + FREE_W'(1);
                        end
                    end
                end
                MODE_LOOKUP: begin
                    if (!pid_ok) begin
                        fin = 1'b1;
                        st  = ST_BAD_SLOT;
                    end else begin
                        go_second = 1'b1;
                    end
                end
                MODE_READ: begin
                    fin    = 1'b1;
                    o_slot = item_reg.slot;
                    st     = slot_ok ? ST_OK : ST_BAD_SLOT;
                end
                default: begin
                    fin = 1'b1;
                end
            endcase
        end else if (state_reg == S_SECOND) begin
            // slot table now holds the entry of the mapped slot
            fin    = 1'b1;
            o_slot = map_rd_reg;
            if (item_reg.mode == MODE_DETACH) begin
                if (cur_alive == '0) begin
                    st = ST_ALIVE_ZERO;
                end else if (cur_refs == '0) begin
                    st = ST_REF_ZERO;
                end else if (cur_refs == REF_ONE && free_top_reg >= SLOT_LIMIT) begin
                    st = ST_STACK_FULL;
                end else begin
                    n_alive = cur_alive - ALIVE_W'(1);
                    n_refs  = cur_refs - REF_ONE;
                    tbl_wr  = 1'b1;
                    map_wr  = 1'b1;
                    if (cur_refs == REF_ONE) begin
                        o_rel = 1'b1;
                        push  = 1'b1;
                        ft_c  = free_top_reg + FREE_W'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        res_c.status     = st;
        res_c.slot_out   = o_slot;
        res_c.released   = o_rel;
        res_c.free_count = ft_c;
        if (o_slot < SLOT_LIMIT) begin
            res_c.ref_count   = REFO_W'(32'(n_refs));
            res_c.alive_count = n_alive;
            res_c.owner_out   = n_owner;
        end else begin
            res_c.ref_count   = '0;
            res_c.alive_count = '0;
            res_c.owner_out   = '0;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_idx_reg == MAP_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (go_second) begin
                    state_next = S_SECOND;
                end else if (commit) begin
                    state_next = push ? S_PUSH : S_IDLE;
                end
            end
            S_SECOND: begin
                if (commit) begin
                    state_next = push ? S_PUSH : S_IDLE;
                end
            end
            S_PUSH: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_idx_reg  <= '0;
            free_top_reg <= FREE_W'(SLOT_COUNT);
            tbl_vld_reg  <= '0;
            stk_vld_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + MAP_AW'(1);
            end
            if (commit) begin
                free_top_reg <= ft_c;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (tbl_we) begin
                tbl_vld_reg[slot_wa] <= 1'b1;
            end
            if (stk_we) begin
                stk_vld_reg[slot_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_in;
        end
        if (commit) begin
            res_reg <= res_c;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'(res_reg);

    // ---------------- assertions ----------------
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_top_reg <= FREE_W'(SLOT_COUNT))
        else $error("free stack count above pool size");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_EXEC)
        else $error("accepted item did not start execution");

    a_release_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && o_rel) |=> state_reg == S_PUSH
                              && free_top_reg == $past(free_top_reg) + FREE_W'(1))
        else $error("released slot not pushed");

    a_release_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.released) |-> (res_reg.status == ST_OK
                                               && res_reg.ref_count == '0))
        else $error("release reported with bad status or nonzero count");

endmodule

[tb/sv/refcounted_slot_allocator_tb.sv]
module refcounted_slot_allocator_tb
    import rsa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NSLOT       = 128;
    localparam int unsigned REF_MAX     = 32'h00FF_FFFF;
    localparam int          STALL_LIMIT = 100000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RAND_ITEMS  = 200;

    // shadow of the allocator: process map, slot tables and the free stack
    class slot_scoreboard;
        logic [SLOT_W-1:0]  pid_map [PID_SPAN];
        int unsigned        ref_cnt [NSLOT];
        int unsigned        alive_cnt [NSLOT];
        logic [OWNER_W-1:0] owner_of [NSLOT];
        int unsigned        free_stack [NSLOT];
        int unsigned        free_top;
        result_t            pending_results [$];
        int                 errors;

        function new();
            foreach (pid_map[i]) pid_map[i] = NONE_SLOT;
            for (int i = 0; i < NSLOT; i++) begin
                ref_cnt[i]    = 0;
                alive_cnt[i]  = 0;
                owner_of[i]   = '0;
                free_stack[i] = NSLOT - 1 - i;
            end
            free_top = NSLOT;
            errors   = 0;
        endfunction

        function void post(status_t st, int unsigned s, bit rel);
            result_t r;
            r.status     = st;
            r.slot_out   = s[SLOT_W-1:0];
            r.released   = rel;
            if (s < NSLOT) begin
                r.ref_count   = ref_cnt[s][REFO_W-1:0];
                r.alive_count = alive_cnt[s][ALIVE_W-1:0];
                r.owner_out   = owner_of[s];
            end else begin
                r.ref_count   = '0;
                r.alive_count = '0;
                r.owner_out   = '0;
            end
            r.free_count = free_top[FREE_W-1:0];
            pending_results.push_back(r);
        endfunction

        // slot whose count hit zero goes back on the stack
        function void put_back(int unsigned s);
            if (free_top < NSLOT) begin
                free_stack[free_top] = s;
                free_top++;
            end
            post(ST_OK, s, 1'b1);
        endfunction

        function void apply_command(item_t it);
            int unsigned s;
            int unsigned m;
            int unsigned pid;
            s   = 32'(it.slot);
            pid = 32'(it.pid);
            case (it.mode)
                MODE_ALLOC: begin
                    if (free_top == 0) begin
                        post(ST_NO_FREE, 32'(NONE_SLOT), 1'b0);
                    end else begin
                        free_top--;
                        m = free_stack[free_top];
                        owner_of[m]  = it.owner_id;
                        alive_cnt[m] = 0;
                        ref_cnt[m]   = 1;
                        post(ST_OK, m, 1'b0);
                    end
                end
                MODE_ATTACH: begin
                    if (s >= NSLOT) begin
                        post(ST_BAD_SLOT, s, 1'b0);
                    end else if (pid_map[pid] != NONE_SLOT) begin
                        post(ST_ATTACHED, s, 1'b0);
                    end else if (ref_cnt[s] >= REF_MAX || alive_cnt[s] >= 32'(ALIVE_MAX)) begin
                        post(ST_OVERFLOW, s, 1'b0);
                    end else begin
                        pid_map[pid] = s[SLOT_W-1:0];
                        alive_cnt[s]++;
                        ref_cnt[s]++;
                        post(ST_OK, s, 1'b0);
                    end
                end
                MODE_DETACH: begin
                    m = 32'(pid_map[pid]);
                    if (m == 32'(NONE_SLOT)) begin
                        post(ST_OK, 32'(NONE_SLOT), 1'b0);
                    end else if (m >= NSLOT) begin
                        post(ST_BAD_SLOT, m, 1'b0);
                    end else if (alive_cnt[m] == 0) begin
                        post(ST_ALIVE_ZERO, m, 1'b0);
                    end else if (ref_cnt[m] == 0) begin
                        post(ST_REF_ZERO, m, 1'b0);
                    end else if (ref_cnt[m] == 1 && free_top >= NSLOT) begin
                        post(ST_STACK_FULL, m, 1'b0);
                    end else begin
                        alive_cnt[m]--;
                        ref_cnt[m]--;
                        pid_map[pid] = NONE_SLOT;
                        if (ref_cnt[m] == 0) put_back(m);
                        else post(ST_OK, m, 1'b0);
                    end
                end
                MODE_ADD: begin
                    if (s >= NSLOT) begin
                        post(ST_BAD_SLOT, s, 1'b0);
                    end else if (ref_cnt[s] >= REF_MAX) begin
                        post(ST_OVERFLOW, s, 1'b0);
                    end else begin
                        ref_cnt[s]++;
                        post(ST_OK, s, 1'b0);
                    end
                end
                MODE_DROP: begin
                    if (s >= NSLOT) begin
                        post(ST_BAD_SLOT, s, 1'b0);
                    end else if (ref_cnt[s] == 0) begin
                        post(ST_REF_ZERO, s, 1'b0);
                    end else if (ref_cnt[s] == 1 && free_top >= NSLOT) begin
                        post(ST_STACK_FULL, s, 1'b0);
                    end else begin
                        ref_cnt[s]--;
                        if (ref_cnt[s] == 0) put_back(s);
                        else post(ST_OK, s, 1'b0);
                    end
                end
                MODE_LOOKUP: post(ST_OK, 32'(pid_map[pid]), 1'b0);
                MODE_READ:   post((s < NSLOT) ? ST_OK : ST_BAD_SLOT, s, 1'b0);
                default:     post(ST_OK, 32'(NONE_SLOT), 1'b0);
            endcase
        endfunction

        function void compare_field(string name, longint unsigned exp_v, longint unsigned got_v);
            if (exp_v != got_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (pending_results.size() == 0) begin
                $error("result item with no command pending");
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            compare_field("status", exp_r.status, got.status);
            compare_field("slot_out", exp_r.slot_out, got.slot_out);
            compare_field("released", exp_r.released, got.released);
            compare_field("ref_count", exp_r.ref_count, got.ref_count);
            compare_field("alive_count", exp_r.alive_count, got.alive_count);
            compare_field("owner_out", exp_r.owner_out, got.owner_out);
            compare_field("free_count", exp_r.free_count, got.free_count);
        endfunction

        // a slot that is currently handed out, if any
        function int unsigned live_slot();
            int unsigned start;
            start = $urandom_range(NSLOT - 1);
            for (int i = 0; i < NSLOT; i++) begin
                if (ref_cnt[(start + i) % NSLOT] != 0) return (start + i) % NSLOT;
            end
            return start;
        endfunction
    endclass

    logic             aclk;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    slot_scoreboard sb = new();
    int  src_idle_pct  = 0;
    int  sink_idle_pct = 0;
    bit  hold_off      = 1'b0;
    int  accepted_cnt  = 0;
    int  stall_cycles  = 0;

    // mode weights per random phase: general mix, allocate-heavy, release-heavy
    int mode_wt [3][8] = '{'{18, 20, 14, 10, 14, 8, 8, 8},
                           '{70,  8,  6,  4,  4, 3, 3, 2},
                           '{ 4, 12, 28,  6, 34, 6, 6, 4}};

    refcounted_slot_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.apply_command(item_t'(s_tdata[ITEM_W-1:0]));
                accepted_cnt++;
            end
            if (m_tvalid && m_tready) sb.check_result(result_t'(m_tdata[RES_W-1:0]));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // long receiver stall while commands keep coming, so the input backs up
    initial begin
        do @(posedge aclk); while (accepted_cnt < 150);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic send_command(input item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - ITEM_W){1'b0}}, it};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic issue(input mode_t m, input int pid, input int slot, input int owner);
        item_t it;
        it.mode     = m;
        it.pid      = pid[PID_W-1:0];
        it.slot     = slot[SLOT_W-1:0];
        it.owner_id = owner[OWNER_W-1:0];
        send_command(it);
    endtask

    function automatic item_t random_command(input int phase);
        item_t it;
        int    r;
        int    acc;
        int    m;
        r   = $urandom_range(99);
        acc = 0;
        m   = 7;
        for (int i = 0; i < 8; i++) begin
            acc += mode_wt[phase][i];
            if (r < acc) begin
                m = i;
                break;
            end
        end
        it.mode = mode_t'(m);
        r = $urandom_range(99);
        if (r < 65)      it.slot = SLOT_W'(sb.live_slot());
        else if (r < 90) it.slot = SLOT_W'($urandom_range(NSLOT - 1));
        else             it.slot = SLOT_W'($urandom_range(255));
        // small pid pool so detach and lookup find mapped processes
        if ($urandom_range(99) < 70) it.pid = PID_W'($urandom_range(63));
        else                         it.pid = PID_W'($urandom);
        it.owner_id = OWNER_W'($urandom);
        return it;
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn       <= 1'b1;
        src_idle_pct  <= 6;
        sink_idle_pct <= 53;

        issue(MODE_READ,   0,     0,   0);
        issue(MODE_READ,   0,     255, 0);
        issue(MODE_DETACH, 5,     0,   0);      // not sandboxed
        issue(MODE_DROP,   0,     3,   0);      // refcount already zero
        issue(MODE_ADD,    0,     200, 0);
        issue(MODE_ADD,    0,     127, 0);      // unallocated slot
        issue(MODE_DROP,   0,     127, 0);      // release with full stack
        issue(MODE_ATTACH, 32767, 126, 0);
        issue(MODE_DETACH, 32767, 0,   0);      // release with full stack
        issue(MODE_ALLOC,  0,     0,   32767);
        issue(MODE_ALLOC,  0,     0,   0);
        issue(MODE_ATTACH, 0,     0,   0);
        issue(MODE_ATTACH, 0,     1,   0);      // already attached
        issue(MODE_ATTACH, 1,     255, 0);
        issue(MODE_LOOKUP, 0,     0,   0);
        issue(MODE_DETACH, 0,     0,   0);
        issue(MODE_DROP,   0,     0,   0);      // slot 0 released
        issue(MODE_ATTACH, 2,     1,   0);
        issue(MODE_DROP,   0,     1,   0);
        issue(MODE_DROP,   0,     1,   0);      // slot 1 released, pid 2 still mapped
        issue(MODE_ALLOC,  0,     0,   12345);  // pops slot 1 again
        issue(MODE_DETACH, 2,     0,   0);      // alive count zero
        issue(MODE_ATTACH, 3,     5,   0);
        issue(MODE_DROP,   0,     5,   0);
        issue(MODE_DETACH, 3,     0,   0);      // refcount zero
        issue(MODE_NOP,    21845, 170, 10922);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                src_idle_pct  <= 53;
                sink_idle_pct <= 6;
            end else if (phase == 2) begin
                src_idle_pct  <= 0;
                sink_idle_pct <= 0;
            end
            for (int n = 0; n < RAND_ITEMS; n++) send_command(random_command(phase));
        end
        s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
